@@ src/ltpb_pkg.sv @@
// shared types, constants and fixed-point helpers for the lip tint pixel blend
package ltpb_pkg;

	// pipeline depth, input register to output register
	localparam int NUM_STAGES = 12;

	// Q16 fraction that can hold 1.0
	typedef logic [16:0] q_t;

	localparam q_t Q_ONE  = 17'd65536;
	localparam q_t Q_HALF = 17'd32768;

	// register indexes of the write port
	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t REG_TINT_RED   = 2'd0;
	localparam cfg_idx_t REG_TINT_GREEN = 2'd1;
	localparam cfg_idx_t REG_TINT_BLUE  = 2'd2;

	localparam logic [7:0] TINT_RED_RST   = 8'd200;
	localparam logic [7:0] TINT_GREEN_RST = 8'd40;
	localparam logic [7:0] TINT_BLUE_RST  = 8'd60;

	// teeth guard codes and their Q16 factors
	typedef logic [1:0] guard_t;
	localparam guard_t GUARD_NONE   = 2'd0;
	localparam guard_t GUARD_BRIGHT = 2'd1;
	localparam guard_t GUARD_TEETH  = 2'd2;

	localparam q_t GUARD_NONE_VAL   = 17'd65536;
	localparam q_t GUARD_BRIGHT_VAL = 17'd16384;
	localparam q_t GUARD_TEETH_VAL  = 17'd5243;

	// luma weights in Q16
	localparam logic [23:0] LUMA_R = 24'd19595;
	localparam logic [23:0] LUMA_G = 24'd38470;
	localparam logic [23:0] LUMA_B = 24'd7471;

	// luma thresholds in Q16
	localparam logic [23:0] Y_RAMP_LO = 24'd9830400;
	localparam logic [23:0] Y_RAMP_HI = 24'd14090240;
	localparam logic [23:0] Y_TEETH   = 24'd14942208;
	localparam logic [23:0] Y_BRIGHT  = 24'd13893632;
	localparam logic [23:0] Y_DIM     = 24'd12976128;

	// reciprocals for the constant divides (x * m >> s)
	localparam logic [19:0] RECIP_5     = 20'd838861;   // s = 22
	localparam logic [19:0] RECIP_9     = 20'd932068;   // s = 23
	localparam logic [21:0] RECIP_65    = 22'd4129777;  // s = 28
	localparam logic [21:0] RECIP_43    = 22'd3121343;  // s = 27

	localparam q_t SHADE_MIN = 17'd36045;
	localparam q_t SHADE_MAX = 17'd79954;

	localparam q_t SHADOW_GAIN = 17'd53740;
	localparam q_t CONF_BASE   = 17'd31457;
	localparam q_t CONF_GAIN   = 17'd34079;
	localparam q_t CONF_DIM    = 17'd51118;
	localparam q_t CONF_MIN    = 17'd23593;

	typedef struct packed {
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
		logic [9:0] blend_amount;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
	} pix_out_t;

	// rounded Q16 product of two fractions no larger than 1.0
	function automatic q_t qmul_round(input q_t a, input q_t b);
		logic [33:0] p;
		p = 34'(a) * 34'(b) + 34'(Q_HALF);
		return p[32:16];
	endfunction

endpackage

@@ src/ltpb_pipe_ctrl.sv @@
// valid bits and per-stage load enables of the blend pipeline
module ltpb_pipe_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ltpb_pkg::NUM_STAGES-1:0]   stage_en
);
	import ltpb_pkg::*;

	logic [NUM_STAGES-1:0] valid_q;
	logic [NUM_STAGES-1:0] valid_nxt;

	// a stage loads when it is empty or its request moves on
	always_comb begin
		stage_en[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || out_ready;
		for (int i = NUM_STAGES - 2; i >= 0; i--) begin
			stage_en[i] = !valid_q[i] || stage_en[i+1];
		end
	end

	assign valid_nxt = {valid_q[NUM_STAGES-2:0], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int i = 0; i < NUM_STAGES; i++) begin
				if (stage_en[i]) begin
					valid_q[i] <= valid_nxt[i];
				end
			end
		end
	end

	assign in_ready  = stage_en[0];
	assign out_valid = valid_q[NUM_STAGES-1];

endmodule

@@ src/ltpb_ramp.sv @@
// two-stage smoothstep polynomial 3t^2 - 2t^3 with edge clamps
module ltpb_ramp (
	input  logic          clk,
	input  logic          en_a,
	input  logic          en_b,
	input  ltpb_pkg::q_t  t,
	input  logic          lo,
	input  logic          hi,
	output ltpb_pkg::q_t  s
);
	import ltpb_pkg::*;

	q_t          t_s3;
	q_t          t2_s3;
	logic        lo_s3;
	logic        hi_s3;
	q_t          s_s4;
	logic [17:0] cubic_w;
	logic [34:0] cubic_p;
	q_t          poly;

	always_ff @(posedge clk) begin
		if (en_a) begin
			t_s3  <= t;
			t2_s3 <= qmul_round(t, t);
			lo_s3 <= lo;
			hi_s3 <= hi;
		end
	end

	always_comb begin
		cubic_w = 18'd196608 - {t_s3, 1'b0};
		cubic_p = 35'(t2_s3) * 35'(cubic_w) + 35'(Q_HALF);
		poly    = cubic_p[32:16];
	end

	always_ff @(posedge clk) begin
		if (en_b) begin
			if (lo_s3) begin
				s_s4 <= '0;
			end else if (hi_s3) begin
				s_s4 <= Q_ONE;
			end else begin
				s_s4 <= poly;
			end
		end
	end

	assign s = s_s4;

endmodule

@@ src/ltpb_mix.sv @@
// two-stage mix of one channel with the shaded tint, saturated to 8 bits
module ltpb_mix (
	input  logic          clk,
	input  logic          en_a,
	input  logic          en_b,
	input  logic [7:0]    chan,
	input  logic [7:0]    tint,
	input  ltpb_pkg::q_t  shade,
	input  ltpb_pkg::q_t  amt,
	output logic [7:0]    res
);
	import ltpb_pkg::*;

	logic [24:0] keep_s11;
	logic [24:0] tint_sh_s11;
	q_t          amt_s11;
	logic [41:0] mix_sum;
	logic [9:0]  mix_int;
	logic [7:0]  res_s12;

	always_ff @(posedge clk) begin
		if (en_a) begin
			keep_s11    <= 25'(chan) * 25'(Q_ONE - amt);
			tint_sh_s11 <= 25'(tint) * 25'(shade);
			amt_s11     <= amt;
		end
	end

	always_comb begin
		mix_sum = {1'b0, keep_s11, 16'b0} + 42'(tint_sh_s11) * 42'(amt_s11);
		mix_int = mix_sum[41:32];
	end

	always_ff @(posedge clk) begin
		if (en_b) begin
			res_s12 <= (mix_int > 10'd255) ? 8'd255 : mix_int[7:0];
		end
	end

	assign res = res_s12;

endmodule

@@ src/lip_tint_pixel_blend.sv @@
// top level: lip tint pixel blend pipeline with tint registers
// throughput: one pixel per cycle unless the sink stalls,
// set by twelve register stages that each carry a valid bit
// an output stall holds the full stages ahead of the first bubble, stages behind it keep filling
// ready toward the source drops only when all twelve stages are full and the sink stalls
// reset: clears all pipeline valid bits and loads the default tint 200/40/60
module lip_tint_pixel_blend (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ltpb_pkg::pix_in_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ltpb_pkg::pix_out_t  out_data,
	input  logic                cfg_we,
	input  ltpb_pkg::cfg_idx_t  cfg_index,
	input  logic [7:0]          cfg_data
);
	import ltpb_pkg::*;

	logic [NUM_STAGES-1:0] en;

	logic [7:0] tint_red_q;
	logic [7:0] tint_green_q;
	logic [7:0] tint_blue_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tint_red_q   <= TINT_RED_RST;
			tint_green_q <= TINT_GREEN_RST;
			tint_blue_q  <= TINT_BLUE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TINT_RED:   tint_red_q   <= cfg_data;
				REG_TINT_GREEN: tint_green_q <= cfg_data;
				REG_TINT_BLUE:  tint_blue_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	ltpb_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stage_en  (en)
	);

	// stage 1: luma, chroma, channel differences
	logic [7:0]        ch_max;
	logic [7:0]        ch_min;
	logic [23:0]       y16_c;
	pix_in_t           pix_s1;
	logic [23:0]       y16_s1;
	logic [7:0]        chroma_s1;
	logic signed [8:0] d_rg_s1;
	logic signed [8:0] d_rb_s1;

	always_comb begin
		ch_max = in_data.in_red;
		ch_min = in_data.in_red;
		if (in_data.in_green > ch_max) ch_max = in_data.in_green;
		if (in_data.in_blue > ch_max) ch_max = in_data.in_blue;
		if (in_data.in_green < ch_min) ch_min = in_data.in_green;
		if (in_data.in_blue < ch_min) ch_min = in_data.in_blue;
		y16_c = LUMA_R * 24'(in_data.in_red) + LUMA_G * 24'(in_data.in_green)
			+ LUMA_B * 24'(in_data.in_blue);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			pix_s1    <= in_data;
			y16_s1    <= y16_c;
			chroma_s1 <= ch_max - ch_min;
			d_rg_s1   <= $signed({1'b0, in_data.in_red}) - $signed({1'b0, in_data.in_green});
			d_rb_s1   <= $signed({1'b0, in_data.in_red}) - $signed({1'b0, in_data.in_blue});
		end
	end

	// stage 2: ramp positions by shift or reciprocal multiply, shade, guard and dim flags
	logic signed [8:0] k_rg;
	logic signed [8:0] k_rb;
	logic [7:0]        k_c;
	logic [18:0]       num_rb;
	logic [19:0]       num_c;
	logic [23:0]       num_y;
	logic [23:0]       num_sh;
	logic [38:0]       prod_rb;
	logic [39:0]       prod_c;
	logic [44:0]       prod_y;
	logic [43:0]       prod_sh;
	guard_t            guard_c;

	always_comb begin
		k_rg    = d_rg_s1 + 9'sd4;
		k_rb    = d_rb_s1 + 9'sd16;
		k_c     = chroma_s1 - 8'd6;
		num_rb  = {k_rb[5:0], 13'd2};
		num_c   = {k_c[5:0], 14'd4};
		num_y   = y16_s1 - Y_RAMP_LO + 24'd32;
		num_sh  = y16_s1 + 24'd86;
		prod_rb = 39'(num_rb) * 39'(RECIP_5);
		prod_c  = 40'(num_c) * 40'(RECIP_9);
		prod_y  = 45'(num_y[22:0]) * 45'(RECIP_65);
		prod_sh = 44'(num_sh[23:2]) * 44'(RECIP_43);
		if (y16_s1 > Y_TEETH && chroma_s1 < 8'd34) begin
			guard_c = GUARD_TEETH;
		end else if (y16_s1 > Y_BRIGHT && chroma_s1 < 8'd24) begin
			guard_c = GUARD_BRIGHT;
		end else begin
			guard_c = GUARD_NONE;
		end
	end

	pix_in_t pix_s2;
	q_t      t_rg_s2, t_rb_s2, t_c_s2, t_y_s2;
	logic    lo_rg_s2, hi_rg_s2, lo_rb_s2, hi_rb_s2;
	logic    lo_c_s2, hi_c_s2, lo_y_s2, hi_y_s2;
	q_t      shade_raw_s2;
	guard_t  guard_s2;
	logic    dim_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			pix_s2       <= pix_s1;
			t_rg_s2      <= {1'b0, k_rg[4:0], 11'b0};
			t_rb_s2      <= prod_rb[38:22];
			t_c_s2       <= prod_c[39:23];
			t_y_s2       <= prod_y[44:28];
			lo_rg_s2     <= d_rg_s1 <= -9'sd4;
			hi_rg_s2     <= d_rg_s1 >= 9'sd28;
			lo_rb_s2     <= d_rb_s1 <= -9'sd16;
			hi_rb_s2     <= d_rb_s1 >= 9'sd24;
			lo_c_s2      <= chroma_s1 <= 8'd6;
			hi_c_s2      <= chroma_s1 >= 8'd42;
			lo_y_s2      <= y16_s1 <= Y_RAMP_LO;
			hi_y_s2      <= y16_s1 >= Y_RAMP_HI;
			shade_raw_s2 <= prod_sh[43:27];
			guard_s2     <= guard_c;
			dim_s2       <= y16_s1 > Y_DIM && chroma_s1 < 8'd30;
		end
	end

	// stages 3 and 4: smoothstep polynomials, with the shade clamp in stage 3
	q_t s_rg, s_rb, s_c, s_y;

	ltpb_ramp u_ramp_rg (
		.clk (clk), .en_a (en[2]), .en_b (en[3]),
		.t (t_rg_s2), .lo (lo_rg_s2), .hi (hi_rg_s2), .s (s_rg)
	);

	ltpb_ramp u_ramp_rb (
		.clk (clk), .en_a (en[2]), .en_b (en[3]),
		.t (t_rb_s2), .lo (lo_rb_s2), .hi (hi_rb_s2), .s (s_rb)
	);

	ltpb_ramp u_ramp_c (
		.clk (clk), .en_a (en[2]), .en_b (en[3]),
		.t (t_c_s2), .lo (lo_c_s2), .hi (hi_c_s2), .s (s_c)
	);

	ltpb_ramp u_ramp_y (
		.clk (clk), .en_a (en[2]), .en_b (en[3]),
		.t (t_y_s2), .lo (lo_y_s2), .hi (hi_y_s2), .s (s_y)
	);

	pix_in_t pix_s3, pix_s4;
	q_t      shade_s3, shade_s4;
	guard_t  guard_s3, guard_s4;
	logic    dim_s3, dim_s4;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			pix_s3   <= pix_s2;
			guard_s3 <= guard_s2;
			dim_s3   <= dim_s2;
			if (shade_raw_s2 < SHADE_MIN) begin
				shade_s3 <= SHADE_MIN;
			end else if (shade_raw_s2 > SHADE_MAX) begin
				shade_s3 <= SHADE_MAX;
			end else begin
				shade_s3 <= shade_raw_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			pix_s4   <= pix_s3;
			shade_s4 <= shade_s3;
			guard_s4 <= guard_s3;
			dim_s4   <= dim_s3;
		end
	end

	// stage 5: warmth and shadow terms
	pix_in_t pix_s5;
	q_t      shade_s5, warm_s5, shadow_s5, s_c_s5;
	guard_t  guard_s5;
	logic    dim_s5;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			pix_s5    <= pix_s4;
			shade_s5  <= shade_s4;
			guard_s5  <= guard_s4;
			dim_s5    <= dim_s4;
			warm_s5   <= qmul_round(s_rg, s_rb);
			shadow_s5 <= qmul_round(Q_ONE - s_y, SHADOW_GAIN);
			s_c_s5    <= s_c;
		end
	end

	// stage 6: lip chroma term
	pix_in_t pix_s6;
	q_t      shade_s6, lc_s6, shadow_s6;
	guard_t  guard_s6;
	logic    dim_s6;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			pix_s6    <= pix_s5;
			shade_s6  <= shade_s5;
			guard_s6  <= guard_s5;
			dim_s6    <= dim_s5;
			lc_s6     <= qmul_round(s_c_s5, warm_s5);
			shadow_s6 <= shadow_s5;
		end
	end

	// stage 7: raw confidence from the stronger term
	q_t      best;
	pix_in_t pix_s7;
	q_t      shade_s7, conf_s7;
	guard_t  guard_s7;
	logic    dim_s7;

	assign best = (lc_s6 > shadow_s6) ? lc_s6 : shadow_s6;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			pix_s7   <= pix_s6;
			shade_s7 <= shade_s6;
			guard_s7 <= guard_s6;
			dim_s7   <= dim_s6;
			conf_s7  <= CONF_BASE + qmul_round(CONF_GAIN, best);
		end
	end

	// stage 8: bright low-chroma damping and clamp
	q_t      conf_dim;
	pix_in_t pix_s8;
	q_t      shade_s8, conf_s8;
	guard_t  guard_s8;

	assign conf_dim = dim_s7 ? qmul_round(conf_s7, CONF_DIM) : conf_s7;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			pix_s8   <= pix_s7;
			shade_s8 <= shade_s7;
			guard_s8 <= guard_s7;
			if (conf_dim < CONF_MIN) begin
				conf_s8 <= CONF_MIN;
			end else if (conf_dim > Q_ONE) begin
				conf_s8 <= Q_ONE;
			end else begin
				conf_s8 <= conf_dim;
			end
		end
	end

	// stage 9: weight times confidence
	pix_in_t     pix_s9;
	q_t          shade_s9;
	guard_t      guard_s9;
	logic [26:0] wc_s9;

	always_ff @(posedge clk) begin
		if (en[8]) begin
			pix_s9   <= pix_s8;
			shade_s9 <= shade_s8;
			guard_s9 <= guard_s8;
			wc_s9    <= 27'(pix_s8.blend_amount) * 27'(conf_s8);
		end
	end

	// stage 10: guard factor and effective amount
	q_t          guard_val;
	logic [43:0] amt_full;
	logic [19:0] amt_raw;
	pix_in_t     pix_s10;
	q_t          shade_s10, amt_s10;

	always_comb begin
		case (guard_s9)
			GUARD_TEETH:  guard_val = GUARD_TEETH_VAL;
			GUARD_BRIGHT: guard_val = GUARD_BRIGHT_VAL;
			default:      guard_val = GUARD_NONE_VAL;
		endcase
		amt_full = 44'(wc_s9) * 44'(guard_val) + 44'(24'h800000);
		amt_raw  = amt_full[43:24];
	end

	always_ff @(posedge clk) begin
		if (en[9]) begin
			pix_s10   <= pix_s9;
			shade_s10 <= shade_s9;
			amt_s10   <= (amt_raw > 20'(Q_ONE)) ? Q_ONE : amt_raw[16:0];
		end
	end

	// stages 11 and 12: per-channel mix
	logic [7:0] mix_red;
	logic [7:0] mix_green;
	logic [7:0] mix_blue;

	ltpb_mix u_mix_r (
		.clk (clk), .en_a (en[10]), .en_b (en[11]),
		.chan (pix_s10.in_red), .tint (tint_red_q),
		.shade (shade_s10), .amt (amt_s10), .res (mix_red)
	);

	ltpb_mix u_mix_g (
		.clk (clk), .en_a (en[10]), .en_b (en[11]),
		.chan (pix_s10.in_green), .tint (tint_green_q),
		.shade (shade_s10), .amt (amt_s10), .res (mix_green)
	);

	ltpb_mix u_mix_b (
		.clk (clk), .en_a (en[10]), .en_b (en[11]),
		.chan (pix_s10.in_blue), .tint (tint_blue_q),
		.shade (shade_s10), .amt (amt_s10), .res (mix_blue)
	);

	assign out_data = {mix_red, mix_green, mix_blue};

endmodule
